// ===== src/iir_tdf_pkg.sv =====
package iir_tdf_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 28;
  localparam int COEF_BITS          = 32;
  localparam int DELAY_BITS         = 56;
  localparam int CFG_IDX_BITS       = 3;

  // register map
  localparam logic [CFG_IDX_BITS-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_A2 = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_G0 = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_G1 = 3'd6;

  // operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MUL_G0X,
    MUL_G1X,
    MUL_B0X,
    MUL_B1X,
    MUL_B2X,
    MUL_A1Y,
    MUL_A2Y
  } mul_sel_t;

  // what the datapath does with the registered product
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LD_D0,
    OP_LD_D1,
    OP_OUT,
    OP_T0,
    OP_T1,
    OP_D0,
    OP_D1
  } dp_op_t;

  typedef struct packed {
    logic     in_load;
    logic     mul_en;
    mul_sel_t mul_sel;
    dp_op_t   op;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// ===== src/iir_tdf_ctrl.sv =====
module iir_tdf_ctrl
  import iir_tdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_block_start,
  output logic     in_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_G0,
    S_G1,
    S_G2,
    S_B0,
    S_B1,
    S_B2,
    S_A1,
    S_A2,
    S_FIN,
    S_PUB
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.in_load  = 1'b0;
    cmd.mul_en   = 1'b0;
    cmd.mul_sel  = MUL_B0X;
    cmd.op       = OP_NOP;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_load = in_valid;
        if (in_valid) begin
          state_nxt = in_block_start ? S_G0 : S_B0;
        end
      end
      S_G0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_G0X;
        state_nxt   = S_G1;
      end
      S_G1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_G1X;
        cmd.op      = OP_LD_D0;
        state_nxt   = S_G2;
      end
      S_G2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_B0X;
        cmd.op      = OP_LD_D1;
        state_nxt   = S_B1;
      end
      S_B0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_B0X;
        state_nxt   = S_B1;
      end
      S_B1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_B1X;
        cmd.op      = OP_OUT;
        state_nxt   = S_B2;
      end
      S_B2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_B2X;
        cmd.op      = OP_T0;
        state_nxt   = S_A1;
      end
      S_A1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_A1Y;
        cmd.op      = OP_T1;
        state_nxt   = S_A2;
      end
      S_A2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_A2Y;
        cmd.op      = OP_D0;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        cmd.op    = OP_D1;
        state_nxt = S_PUB;
      end
      S_PUB: begin
        cmd.out_load = stat.out_free;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/iir_tdf_dp.sv =====
module iir_tdf_dp
  import iir_tdf_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]    cfg_wdata,
  input  logic [SAMPLE_BITS-1:0]  in_sample_in,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SAMPLE_BITS-1:0]  out_sample_out,
  output logic                    out_clipped
);

  localparam int P_W   = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W = ((P_W > DELAY_BITS) ? P_W : DELAY_BITS) + 2;
  localparam logic [COEF_BITS-1:0] B0_RESET = COEF_BITS'(1) << COEF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] Y_MAX =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;
  localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic signed [COEF_BITS-1:0]   b0_r, b1_r, b2_r, a1_r, a2_r, g0_r, g1_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic                          clip_r;
  logic signed [DELAY_BITS-1:0]  d0_r, d1_r, t0_r, t1_r;
  logic signed [P_W-1:0]         p_r;
  logic                          out_valid_r;
  logic [SAMPLE_BITS-1:0]        out_sample_r;
  logic                          out_clip_r;

  logic signed [COEF_BITS-1:0]   mul_a;
  logic signed [SAMPLE_BITS-1:0] mul_b;
  logic signed [P_W-1:0]         mul_p;
  logic signed [ACC_W-1:0]       p_ext, d0_ext, acc, acc_sh;
  logic [DELAY_BITS-1:0]         p_d;
  logic signed [SAMPLE_BITS-1:0] y_nxt;
  logic                          clip_nxt;

  // configuration registers, bits above the register width already dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= B0_RESET;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
      g0_r <= '0;
      g1_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_B0:  b0_r <= cfg_wdata;
        REG_B1:  b1_r <= cfg_wdata;
        REG_B2:  b2_r <= cfg_wdata;
        REG_A1:  a1_r <= cfg_wdata;
        REG_A2:  a2_r <= cfg_wdata;
        REG_G0:  g0_r <= cfg_wdata;
        REG_G1:  g1_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // shared multiplier, one product per cycle
  always_comb begin
    mul_a = b0_r;
    mul_b = x_r;
    unique case (cmd.mul_sel)
      MUL_G0X: begin mul_a = g0_r; mul_b = x_r; end
      MUL_G1X: begin mul_a = g1_r; mul_b = x_r; end
      MUL_B0X: begin mul_a = b0_r; mul_b = x_r; end
      MUL_B1X: begin mul_a = b1_r; mul_b = x_r; end
      MUL_B2X: begin mul_a = b2_r; mul_b = x_r; end
      MUL_A1Y: begin mul_a = a1_r; mul_b = y_r; end
      MUL_A2Y: begin mul_a = a2_r; mul_b = y_r; end
      default: begin mul_a = b0_r; mul_b = x_r; end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign p_ext  = ACC_W'(p_r);
  assign d0_ext = ACC_W'(d0_r);
  assign p_d    = p_ext[DELAY_BITS-1:0];

  // round half up, then clamp to the sample range
  assign acc    = p_ext + d0_ext + HALF;
  assign acc_sh = acc >>> COEF_FRAC_BITS;

  always_comb begin
    y_nxt    = acc_sh[SAMPLE_BITS-1:0];
    clip_nxt = 1'b0;
    if (acc_sh > Y_MAX) begin
      y_nxt    = Y_MAX[SAMPLE_BITS-1:0];
      clip_nxt = 1'b1;
    end else if (acc_sh < Y_MIN) begin
      y_nxt    = Y_MIN[SAMPLE_BITS-1:0];
      clip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      x_r <= in_sample_in;
    end
    if (cmd.mul_en) begin
      p_r <= mul_p;
    end
    unique case (cmd.op)
      OP_OUT: begin
        y_r    <= y_nxt;
        clip_r <= clip_nxt;
      end
      OP_T0:   t0_r <= p_d + d1_r;
      OP_T1:   t1_r <= p_d;
      default: ;
    endcase
    if (cmd.out_load) begin
      out_sample_r <= y_r;
      out_clip_r   <= clip_r;
    end
  end

  // delay line, wraps modulo 2^DELAY_BITS
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_r <= '0;
      d1_r <= '0;
    end else begin
      unique case (cmd.op)
        OP_LD_D0: d0_r <= p_d;
        OP_LD_D1: d1_r <= p_d;
        OP_D0:    d0_r <= t0_r - p_d;
        OP_D1:    d1_r <= t1_r - p_d;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free  = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clip_r;

endmodule

// ===== src/iir_filter_transposed_direct_form.sv =====
// Biquad IIR, transposed direct form II, one shared 32 x SAMPLE_BITS multiplier.
// Samples are taken one at a time: a new input transfer waits until the previous
// result has moved into the output register. The five products of a sample, seven
// on a block start, go one after another through the single multiplier.
// Reset (rst_n low, synchronous): delays cleared, b0 = 1.0, other coefficient
// registers 0, no result pending.
module iir_filter_transposed_direct_form
  import iir_tdf_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration writes, only while idle
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]    cfg_wdata,
  // sample input
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_BITS-1:0]  in_sample_in,
  input  logic                    in_block_start,
  // filtered output
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SAMPLE_BITS-1:0]  out_sample_out,
  output logic                    out_clipped
);

  // Schedule per sample (one product issued per step, used on the next):
  //   block start: g0*x -> d0, g1*x -> d1
  //   b0*x + d0 -> y (rounded, saturated)
  //   b1*x + d1 -> t0, b2*x -> t1, d0 = t0 - a1*y, d1 = t1 - a2*y
  // The result sits in an output register; the next transfer is taken once
  // the finished one has moved into it.

  dp_cmd_t  cmd;
  dp_stat_t stat;

  iir_tdf_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_block_start (in_block_start),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .stat           (stat)
  );

  iir_tdf_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_sample_in   (in_sample_in),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import iir_tdf_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int FB = COEF_FRAC_BITS_DEF;

  // spare register index, writes to it must be dropped
  localparam logic [CFG_IDX_BITS-1:0] REG_NONE = 3'd7;

  localparam longint Y_MAX    = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint Y_MIN    = -Y_MAX - 1;
  localparam longint HALF_LSB = longint'(1) <<< (FB - 1);

  localparam int RX_HOLD_CYC = 300;   // long receiver hold-off
  localparam int STUCK_LIMIT = 3000;  // cycles without any transfer or register write
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    logic [SW-1:0] sample;
    logic          clip;
  } filt_out_t;

  typedef enum logic {ROW_CFG, ROW_SMP} row_kind_t;

  // one line of the directed table: a register write or a sample,
  // the latter optionally with a hand-worked result
  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [COEF_BITS-1:0]    data;
    logic [SW-1:0]           x;
    logic                    bs;
    logic                    typed;
    filt_out_t               want;
  } dir_row_t;

  logic                    clk;
  logic                    rst_n          = 1'b0;
  logic                    cfg_wr_en      = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index      = '0;
  logic [COEF_BITS-1:0]    cfg_wdata      = '0;
  logic                    in_valid       = 1'b0;
  logic                    in_stall;
  logic [SW-1:0]           in_sample_in   = '0;
  logic                    in_block_start = 1'b0;
  logic                    out_valid;
  logic                    out_stall      = 1'b0;
  logic [SW-1:0]           out_sample_out;
  logic                    out_clipped;

  iir_filter_transposed_direct_form dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .in_block_start(in_block_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .out_clipped   (out_clipped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Biquad predictor: own copy of the coefficient registers and both delays
  // ---------------------------------------------------------------------------
  logic signed [COEF_BITS-1:0]  coef_q [7];
  logic signed [DELAY_BITS-1:0] dly0, dly1;

  filt_out_t filtered_q [$];  // outputs still owed by the filter
  int        n_bad = 0;

  bit tx_quiet    = 1'b0;  // sender never idles
  bit rx_quiet    = 1'b0;  // receiver never stalls at random
  bit rx_hold_req = 1'b0;  // ask the receiver for one long hold-off

  // One sample through the filter; updates the delays as the block would.
  function automatic filt_out_t filter_step(input logic signed [SW-1:0] x,
                                            input logic bs);
    longint    xs, acc, y, n0, n1;
    filt_out_t r;
    xs = x;
    // block start: preload delays from the initial-state gains, same sample
    if (bs) begin
      dly0 = DELAY_BITS'(longint'(coef_q[REG_G0]) * xs);
      dly1 = DELAY_BITS'(longint'(coef_q[REG_G1]) * xs);
    end
    acc = longint'(coef_q[REG_B0]) * xs + longint'(dly0);
    // round half up, then drop the fraction (arithmetic shift = floor)
    y = (acc + HALF_LSB) >>> FB;
    r.clip = 1'b0;
    if (y > Y_MAX) begin
      y      = Y_MAX;
      r.clip = 1'b1;
    end
    if (y < Y_MIN) begin
      y      = Y_MIN;
      r.clip = 1'b1;
    end
    // feedback uses the saturated output; delays wrap, no saturation
    n0 = longint'(coef_q[REG_B1]) * xs + longint'(dly1) - longint'(coef_q[REG_A1]) * y;
    n1 = longint'(coef_q[REG_B2]) * xs - longint'(coef_q[REG_A2]) * y;
    dly0 = DELAY_BITS'(n0);
    dly1 = DELAY_BITS'(n1);
    r.sample = SW'(y);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus tasks. Each starts and ends just after a falling edge, with no
  // input assigned yet in that time step.
  // ---------------------------------------------------------------------------

  // Stop offering samples and wait until every owed output has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (filtered_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [COEF_BITS-1:0] data);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx <= REG_G1) coef_q[idx] = data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one sample, hold it until the transfer, then book its output.
  task automatic send_sample(input logic [SW-1:0] x, input logic bs,
                             input logic typed, input filt_out_t want);
    filt_out_t p;
    while (!tx_quiet && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_sample_in   <= x;
    in_block_start <= bs;
    do @(posedge clk); while (in_stall);
    p = filter_step(x, bs);
    filtered_q.push_back(typed ? want : p);
    @(negedge clk);
  endtask

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(SW-1){1'b1}}};
      1:       return {1'b1, {(SW-1){1'b0}}};
      2:       return $urandom_range(0, 1) ? '0 : '1;
      3, 4:    return SW'($urandom_range(0, 8192) - 4096);
      default: return SW'($urandom());
    endcase
  endfunction

  function automatic logic [COEF_BITS-1:0] rand_coef();
    case ($urandom_range(0, 4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'($urandom_range(0, 32'h2000_0000) - 32'h1000_0000);
      default: return $urandom();
    endcase
  endfunction

  // Random samples; block starts now and then. Optionally the sender pauses
  // part-way until the filter has handed back everything.
  task automatic run_phase(input int n, input int pause_at);
    for (int k = 0; k < n; k++) begin
      if (k == pause_at) drain();
      send_sample(rand_sample(),
                  (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 11) == 0),
                  1'b0, '0);
    end
  endtask

  // directed table rows
  function automatic dir_row_t set_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                       input logic [COEF_BITS-1:0] data);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic dir_row_t feed(input logic [SW-1:0] x, input logic bs);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_SMP;
    r.x    = x;
    r.bs   = bs;
    return r;
  endfunction

  function automatic dir_row_t feed_chk(input logic [SW-1:0] x, input logic bs,
                                        input logic [SW-1:0] y, input logic clip);
    dir_row_t r;
    r       = feed(x, bs);
    r.typed = 1'b1;
    r.want  = '{sample: y, clip: clip};
    return r;
  endfunction

  dir_row_t dir_rows [$];

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    coef_q         = '{default: '0};
    coef_q[REG_B0] = 32'h1000_0000;
    dly0           = '0;
    dly1           = '0;

    dir_rows = '{
      // reset settings: b0 = 1.0, all else zero, so output equals input
      feed_chk(24'h7FFFFF, 1'b0, 24'h7FFFFF, 1'b0),
      feed_chk(24'h800000, 1'b0, 24'h800000, 1'b0),
      feed_chk(24'h000000, 1'b1, 24'h000000, 1'b0),
      feed_chk(24'hFFFFFF, 1'b0, 24'hFFFFFF, 1'b0),
      feed_chk(24'h000001, 1'b1, 24'h000001, 1'b0),
      // gain just under 8: full scale clips both ways
      set_reg(REG_B0, 32'h7FFF_FFFF),
      feed_chk(24'h7FFFFF, 1'b0, 24'h7FFFFF, 1'b1),
      feed_chk(24'h800000, 1'b0, 24'h800000, 1'b1),
      feed_chk(24'h000000, 1'b0, 24'h000000, 1'b0),
      // gain -8: clipping flips side, small input stays exact
      set_reg(REG_B0, 32'h8000_0000),
      feed_chk(24'h7FFFFF, 1'b0, 24'h800000, 1'b1),
      feed_chk(24'h800000, 1'b0, 24'h7FFFFF, 1'b1),
      feed_chk(24'h000001, 1'b0, 24'hFFFFF8, 1'b0),
      // gain 0.5: halves land on ties, rounded towards plus infinity
      set_reg(REG_B0, 32'h0800_0000),
      feed_chk(24'h000001, 1'b0, 24'h000001, 1'b0),
      feed_chk(24'hFFFFFF, 1'b0, 24'h000000, 1'b0),
      feed_chk(24'hFFFFFD, 1'b0, 24'hFFFFFF, 1'b0),
      // stable biquad with preload gains; spare index must be ignored
      set_reg(REG_B0, 32'h1000_0000),
      set_reg(REG_B1, 32'h2000_0000),
      set_reg(REG_B2, 32'hF000_0000),
      set_reg(REG_A1, 32'hE666_6666),
      set_reg(REG_A2, 32'h0A3D_70A4),
      set_reg(REG_G0, 32'h1800_0000),
      set_reg(REG_G1, 32'hF800_0000),
      set_reg(REG_NONE, 32'hDEAD_BEEF),
      feed(24'h001000, 1'b1),
      feed(24'h000000, 1'b0),
      feed(24'h000000, 1'b0),
      feed(24'h7FFFFF, 1'b0),
      feed(24'h800000, 1'b0),
      feed(24'h000000, 1'b1),
      // every coefficient at an extreme: delays wrap, output saturates
      set_reg(REG_B0, 32'h7FFF_FFFF),
      set_reg(REG_B1, 32'h8000_0000),
      set_reg(REG_B2, 32'h8000_0000),
      set_reg(REG_A1, 32'h7FFF_FFFF),
      set_reg(REG_A2, 32'h7FFF_FFFF),
      set_reg(REG_G0, 32'h7FFF_FFFF),
      set_reg(REG_G1, 32'h8000_0000),
      feed(24'h7FFFFF, 1'b1),
      feed(24'h800000, 1'b0),
      feed(24'h7FFFFF, 1'b0)
    };

    // synchronous reset
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: write_reg(dir_rows[i].idx, dir_rows[i].data);
        ROW_SMP: send_sample(dir_rows[i].x, dir_rows[i].bs, dir_rows[i].typed,
                             dir_rows[i].want);
      endcase
    end

    // random phases, each with fresh coefficients
    for (int p = 0; p < N_PHASES; p++) begin
      logic [COEF_BITS-1:0] vals [7];
      case (p)
        2: vals = '{default: 32'h8000_0000};
        3: vals = '{default: 32'h7FFF_FFFF};
        1, 5: begin
          // double pole at 0.8, small random feed-forward
          vals[REG_B0] = 32'($urandom_range(0, 1 << 24));
          vals[REG_B1] = 32'($urandom_range(0, 1 << 24));
          vals[REG_B2] = 32'($urandom_range(0, 1 << 24));
          vals[REG_A1] = 32'hE666_6666;
          vals[REG_A2] = 32'h0A3D_70A4;
          vals[REG_G0] = rand_coef();
          vals[REG_G1] = rand_coef();
        end
        default: foreach (vals[r]) vals[r] = rand_coef();
      endcase
      // phase 5: no idling on either side; phase 6: receiver holds off at
      // the start while the sender keeps pushing, so the block backs up
      tx_quiet = (p == 5 || p == 6);
      rx_quiet = (p == 5 || p == 6);
      for (int r = 0; r < 7; r++) write_reg(CFG_IDX_BITS'(r), vals[r]);
      if (p == 6) rx_hold_req = 1'b1;
      run_phase(PHASE_ITEMS, (p == 7) ? 40 : -1);
    end

    drain();
    repeat (20) @(negedge clk);
    if (filtered_q.size() != 0)
      $display("%0d filter outputs never arrived", filtered_q.size());
    n_bad += filtered_q.size();
    if (n_bad == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or one long hold-off counted here
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYC - 1) @(negedge clk);
      end else begin
        out_stall <= !rx_quiet && ($urandom_range(0, 99) < 20);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output check: each result transfer against the oldest owed output
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    filt_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected output %0d clip %0b", $signed(out_sample_out), out_clipped);
      end else begin
        e = filtered_q.pop_front();
        if (out_sample_out !== e.sample || out_clipped !== e.clip) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: expected %0d clip %0b, got %0d clip %0b",
                     $signed(e.sample), e.clip, $signed(out_sample_out), out_clipped);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transfer or register write
  // ---------------------------------------------------------------------------
  int stuck_cyc = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      stuck_cyc <= 0;
    end else if (stuck_cyc >= STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stuck_cyc <= stuck_cyc + 1;
    end
  end

endmodule
